### src/complex_3x3_matrix_column_product_core_defines.svh
// assertion macros shared by the rtl files
`ifndef COMPLEX_3X3_MATRIX_COLUMN_PRODUCT_CORE_DEFINES_SVH
`define COMPLEX_3X3_MATRIX_COLUMN_PRODUCT_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked only while out of reset
`define CMCP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);
// checked on every edge, reset included
`define CMCP_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error(msg);
`else
`define CMCP_ASSERT(lbl, prop, msg)
`define CMCP_ASSERT_RST(lbl, prop, msg)
`endif

`endif

### src/cmcp_pkg.sv
`default_nettype none

package cmcp_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int IDX_WIDTH    = 4;
    localparam int OUT_WIDTH    = 35;
    localparam int MAT_DIM      = 3;
    localparam int MAT_ENTRIES  = MAT_DIM * MAT_DIM;
    localparam int QUEUE_DEPTH  = 4;
    // kind bit, last flag and entry index ahead of the samples in a queue word
    localparam int HDR_WIDTH    = 2 + IDX_WIDTH;

    typedef enum logic {
        K_LOAD   = 1'b0,
        K_COLUMN = 1'b1
    } t_kind;

endpackage

`default_nettype wire

### src/cmcp_if.sv
`default_nettype none

interface cmcp_in_if #(
    parameter int SAMPLE_WIDTH = cmcp_pkg::SAMPLE_WIDTH
);
    logic                                   valid;
    logic                                   ready;
    logic                                   op;
    logic        [cmcp_pkg::IDX_WIDTH-1:0]  a_index;
    logic signed [SAMPLE_WIDTH-1:0]         a_re;
    logic signed [SAMPLE_WIDTH-1:0]         a_im;
    logic signed [SAMPLE_WIDTH-1:0]         b0_re;
    logic signed [SAMPLE_WIDTH-1:0]         b0_im;
    logic signed [SAMPLE_WIDTH-1:0]         b1_re;
    logic signed [SAMPLE_WIDTH-1:0]         b1_im;
    logic signed [SAMPLE_WIDTH-1:0]         b2_re;
    logic signed [SAMPLE_WIDTH-1:0]         b2_im;
    logic                                   last_in;

    modport source (
        output valid, op, a_index, a_re, a_im,
               b0_re, b0_im, b1_re, b1_im, b2_re, b2_im, last_in,
        input  ready
    );
    modport sink (
        input  valid, op, a_index, a_re, a_im,
               b0_re, b0_im, b1_re, b1_im, b2_re, b2_im, last_in,
        output ready
    );
endinterface

interface cmcp_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [cmcp_pkg::OUT_WIDTH-1:0]  c0_re;
    logic signed [cmcp_pkg::OUT_WIDTH-1:0]  c0_im;
    logic signed [cmcp_pkg::OUT_WIDTH-1:0]  c1_re;
    logic signed [cmcp_pkg::OUT_WIDTH-1:0]  c1_im;
    logic signed [cmcp_pkg::OUT_WIDTH-1:0]  c2_re;
    logic signed [cmcp_pkg::OUT_WIDTH-1:0]  c2_im;
    logic                                   last_out;

    modport source (
        output valid, c0_re, c0_im, c1_re, c1_im, c2_re, c2_im, last_out,
        input  ready
    );
    modport sink (
        input  valid, c0_re, c0_im, c1_re, c1_im, c2_re, c2_im, last_out,
        output ready
    );
endinterface

`default_nettype wire

### src/complex_3x3_matrix_column_product_core.sv
// an accepted column word passes through the queue and pipeline stages 1 to 4 to its result word
// throughput: one word per cycle, loads and columns alike, while the output is not stalled; 36 products per column
// are formed in parallel, then three adder stages, the last being the output register
// a 4-entry queue separates input acceptance from the arithmetic pipeline
// reset: synchronous active-low, empties queue and pipeline and zeroes matrix A
`default_nettype none

module complex_3x3_matrix_column_product_core #(
    parameter int SAMPLE_WIDTH = cmcp_pkg::SAMPLE_WIDTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    cmcp_in_if.sink     i_in,
    cmcp_out_if.source  o_out
);

    localparam int WORD_WIDTH = cmcp_pkg::HDR_WIDTH + 2 * cmcp_pkg::MAT_DIM * SAMPLE_WIDTH;

    logic                  w_q_valid;
    logic                  w_q_ready;
    logic [WORD_WIDTH-1:0] w_q_word;

    cmcp_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_q_valid (w_q_valid),
        .i_q_ready (w_q_ready),
        .o_q_word  (w_q_word)
    );

    cmcp_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .o_q_ready (w_q_ready),
        .i_q_word  (w_q_word),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire

### src/cmcp_front.sv
`default_nettype none
`include "complex_3x3_matrix_column_product_core_defines.svh"

module cmcp_front #(
    parameter int SAMPLE_WIDTH = cmcp_pkg::SAMPLE_WIDTH,
    localparam int WORD_WIDTH  = cmcp_pkg::HDR_WIDTH + 2 * cmcp_pkg::MAT_DIM * SAMPLE_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    cmcp_in_if.sink                    i_in,
    output logic                       o_q_valid,
    input  wire logic                  i_q_ready,
    output logic [WORD_WIDTH-1:0]      o_q_word
);

    localparam int PTR_WIDTH = $clog2(cmcp_pkg::QUEUE_DEPTH);
    localparam int CNT_WIDTH = $clog2(cmcp_pkg::QUEUE_DEPTH + 1);
    localparam int SMP_WIDTH = 2 * cmcp_pkg::MAT_DIM * SAMPLE_WIDTH;

    logic [WORD_WIDTH-1:0] r_mem [cmcp_pkg::QUEUE_DEPTH];
    logic [PTR_WIDTH-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_WIDTH-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_WIDTH-1:0]  r_count, n_count;

    cmcp_pkg::t_kind       w_kind;
    logic                  w_keep;
    logic                  w_full;
    logic                  w_push;
    logic                  w_pop;
    logic [SMP_WIDTH-1:0]  w_samples;
    logic [WORD_WIDTH-1:0] w_word;

    assign w_kind = cmcp_pkg::t_kind'(i_in.op);
    // loads outside the matrix are taken and dropped here
    assign w_keep = (w_kind == cmcp_pkg::K_COLUMN) ||
                    (i_in.a_index < cmcp_pkg::IDX_WIDTH'(cmcp_pkg::MAT_ENTRIES));
    assign w_full = (r_count == CNT_WIDTH'(cmcp_pkg::QUEUE_DEPTH));

    assign i_in.ready = !w_full;
    assign w_push     = i_in.valid && !w_full && w_keep;
    assign w_pop      = o_q_valid && i_q_ready;

    // a load carries its entry in the first two sample slots
    always_comb begin
        w_samples = '0;
        if (w_kind == cmcp_pkg::K_LOAD) begin
            w_samples[0 +: SAMPLE_WIDTH]            = i_in.a_re;
            w_samples[SAMPLE_WIDTH +: SAMPLE_WIDTH] = i_in.a_im;
        end else begin
            w_samples = {i_in.b2_im, i_in.b2_re, i_in.b1_im, i_in.b1_re,
                         i_in.b0_im, i_in.b0_re};
        end
    end

    assign w_word = {w_kind, i_in.last_in, i_in.a_index, w_samples};

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = PTR_WIDTH'(r_wr_ptr + 1'b1);
        end
        if (w_pop) begin
            n_rd_ptr = PTR_WIDTH'(r_rd_ptr + 1'b1);
        end
        if (w_push && !w_pop) begin
            n_count = CNT_WIDTH'(r_count + 1'b1);
        end else if (!w_push && w_pop) begin
            n_count = CNT_WIDTH'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_word;
        end
    end

    assign o_q_valid = (r_count != '0);
    assign o_q_word  = r_mem[r_rd_ptr];

    `CMCP_ASSERT_RST(a_front_reset_empty, !i_rst_n |=> r_count == '0, "queue not empty after reset")
    `CMCP_ASSERT(a_front_push_count, w_push && !w_pop |=> r_count == $past(r_count) + 1'b1, "queue count missed a push")
    `CMCP_ASSERT(a_front_drop_load, i_in.valid && i_in.ready && !w_keep && !w_pop |=> r_count == $past(r_count), "dropped load changed the queue")

endmodule

`default_nettype wire

### src/cmcp_back.sv
`default_nettype none
`include "complex_3x3_matrix_column_product_core_defines.svh"

module cmcp_back #(
    parameter int SAMPLE_WIDTH = cmcp_pkg::SAMPLE_WIDTH,
    localparam int WORD_WIDTH  = cmcp_pkg::HDR_WIDTH + 2 * cmcp_pkg::MAT_DIM * SAMPLE_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_q_valid,
    output logic                       o_q_ready,
    input  wire logic [WORD_WIDTH-1:0] i_q_word,
    cmcp_out_if.source                 o_out
);

    localparam int DIM    = cmcp_pkg::MAT_DIM;
    localparam int OW     = cmcp_pkg::OUT_WIDTH;
    localparam int NSMP   = 2 * DIM;

    typedef logic signed [OW-1:0]           t_acc;
    typedef logic signed [SAMPLE_WIDTH-1:0] t_smp;

    function automatic t_acc mul_ext(input t_smp x, input t_smp y);
        logic signed [2*SAMPLE_WIDTH-1:0] p;
        p = x * y;
        return OW'(p);
    endfunction

    cmcp_pkg::t_kind                 w_kind;
    logic                            w_last;
    logic [cmcp_pkg::IDX_WIDTH-1:0]  w_idx;
    t_smp                            w_smp [NSMP];
    logic                            w_pop;
    logic                            w_en1, w_en2, w_en3, w_en4;

    t_smp r_mat_re [cmcp_pkg::MAT_ENTRIES];
    t_smp r_mat_im [cmcp_pkg::MAT_ENTRIES];

    logic r_v1, r_v2, r_v3, r_v4;
    logic r_last1, r_last2, r_last3, r_last4;

    t_acc r_p_rr [DIM][DIM];
    t_acc r_p_ii [DIM][DIM];
    t_acc r_p_ri [DIM][DIM];
    t_acc r_p_ir [DIM][DIM];
    t_acc r_t_re [DIM][DIM];
    t_acc r_t_im [DIM][DIM];
    t_acc r_u_re [DIM];
    t_acc r_u_im [DIM];
    t_acc r_h_re [DIM];
    t_acc r_h_im [DIM];
    t_acc r_c_re [DIM];
    t_acc r_c_im [DIM];

    assign w_kind = cmcp_pkg::t_kind'(i_q_word[WORD_WIDTH-1]);
    assign w_last = i_q_word[WORD_WIDTH-2];
    assign w_idx  = i_q_word[WORD_WIDTH-3 -: cmcp_pkg::IDX_WIDTH];

    always_comb begin
        for (int j = 0; j < NSMP; j++) begin
            w_smp[j] = t_smp'(i_q_word[j*SAMPLE_WIDTH +: SAMPLE_WIDTH]);
        end
    end

    // a stage moves on when the one after it is empty or moving
    assign w_en4     = !r_v4 || o_out.ready;
    assign w_en3     = !r_v3 || w_en4;
    assign w_en2     = !r_v2 || w_en3;
    assign w_en1     = !r_v1 || w_en2;
    assign o_q_ready = w_en1;
    assign w_pop     = i_q_valid && w_en1;

    // matrix store: loads take effect in queue order, between columns
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < cmcp_pkg::MAT_ENTRIES; e++) begin
                r_mat_re[e] <= '0;
                r_mat_im[e] <= '0;
            end
        end else if (w_pop && w_kind == cmcp_pkg::K_LOAD) begin
            r_mat_re[w_idx] <= w_smp[0];
            r_mat_im[w_idx] <= w_smp[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= w_pop && (w_kind == cmcp_pkg::K_COLUMN);
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
            if (w_en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // stage 1: all partial products of the column
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_last1 <= w_last;
            for (int r = 0; r < DIM; r++) begin
                for (int k = 0; k < DIM; k++) begin
                    r_p_rr[r][k] <= mul_ext(r_mat_re[r*DIM+k], w_smp[2*k]);
                    r_p_ii[r][k] <= mul_ext(r_mat_im[r*DIM+k], w_smp[2*k+1]);
                    r_p_ri[r][k] <= mul_ext(r_mat_re[r*DIM+k], w_smp[2*k+1]);
                    r_p_ir[r][k] <= mul_ext(r_mat_im[r*DIM+k], w_smp[2*k]);
                end
            end
        end
    end

    // stage 2: complex product of each term
    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_last2 <= r_last1;
            for (int r = 0; r < DIM; r++) begin
                for (int k = 0; k < DIM; k++) begin
                    r_t_re[r][k] <= r_p_rr[r][k] - r_p_ii[r][k];
                    r_t_im[r][k] <= r_p_ri[r][k] + r_p_ir[r][k];
                end
            end
        end
    end

    // stage 3: first two terms summed, third held
    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_last3 <= r_last2;
            for (int r = 0; r < DIM; r++) begin
                r_u_re[r] <= r_t_re[r][0] + r_t_re[r][1];
                r_u_im[r] <= r_t_im[r][0] + r_t_im[r][1];
                r_h_re[r] <= r_t_re[r][2];
                r_h_im[r] <= r_t_im[r][2];
            end
        end
    end

    // stage 4: output register, sums wrap at the output width
    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_last4 <= r_last3;
            for (int r = 0; r < DIM; r++) begin
                r_c_re[r] <= r_u_re[r] + r_h_re[r];
                r_c_im[r] <= r_u_im[r] + r_h_im[r];
            end
        end
    end

    assign o_out.valid    = r_v4;
    assign o_out.c0_re    = r_c_re[0];
    assign o_out.c0_im    = r_c_im[0];
    assign o_out.c1_re    = r_c_re[1];
    assign o_out.c1_im    = r_c_im[1];
    assign o_out.c2_re    = r_c_re[2];
    assign o_out.c2_im    = r_c_im[2];
    assign o_out.last_out = r_last4;

    `CMCP_ASSERT(a_back_load_bubble, w_pop && w_kind == cmcp_pkg::K_LOAD |=> !r_v1, "load word entered the pipeline")
    `CMCP_ASSERT(a_back_out_source, $rose(r_v4) |-> $past(r_v3), "result appeared without a stage 3 word")
    `CMCP_ASSERT(a_back_stage2_hold, r_v2 && !w_en2 |=> r_v2 && $stable(r_last2), "stalled stage 2 word lost")

endmodule

`default_nettype wire

### tb/sv/cmcp_column_checker.sv
`timescale 1ns / 1ps

module cmcp_column_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cmcp_in_if        i_in_bus,
    cmcp_out_if       i_out_bus,
    output int        o_mismatches,
    output int        o_pending
);

    localparam int DIM = cmcp_pkg::MAT_DIM;
    localparam int SW  = cmcp_pkg::SAMPLE_WIDTH;
    localparam int OW  = cmcp_pkg::OUT_WIDTH;
    localparam int NE  = cmcp_pkg::MAT_ENTRIES;

    // parts[2r] is the real and parts[2r+1] the imaginary part of row r
    typedef struct packed {
        logic [2*DIM-1:0][OW-1:0] parts;
        logic                     last;
    } t_column;

    logic signed [SW-1:0] entry_re [NE];
    logic signed [SW-1:0] entry_im [NE];
    t_column              expected_columns [$];
    string                part_names [2*DIM] =
        '{"c0_re", "c0_im", "c1_re", "c1_im", "c2_re", "c2_im"};

    function automatic t_column column_product(
        input logic signed [SW-1:0] b_re [DIM],
        input logic signed [SW-1:0] b_im [DIM],
        input logic                 last
    );
        t_column col;
        longint  acc_re;
        longint  acc_im;
        for (int r = 0; r < DIM; r++) begin
            acc_re = 0;
            acc_im = 0;
            for (int k = 0; k < DIM; k++) begin
                acc_re += longint'(entry_re[r*DIM+k]) * longint'(b_re[k])
                        - longint'(entry_im[r*DIM+k]) * longint'(b_im[k]);
                acc_im += longint'(entry_re[r*DIM+k]) * longint'(b_im[k])
                        + longint'(entry_im[r*DIM+k]) * longint'(b_re[k]);
            end
            // sums wrap at the output width
            col.parts[2*r]   = acc_re[OW-1:0];
            col.parts[2*r+1] = acc_im[OW-1:0];
        end
        col.last = last;
        return col;
    endfunction

    always @(posedge i_clk) begin
        logic signed [SW-1:0] b_re [DIM];
        logic signed [SW-1:0] b_im [DIM];
        t_column              seen;
        t_column              want;
        if (!i_rst_n) begin
            for (int i = 0; i < NE; i++) begin
                entry_re[i] = '0;
                entry_im[i] = '0;
            end
            expected_columns.delete();
            o_mismatches = 0;
        end else begin
            if (i_in_bus.valid && i_in_bus.ready) begin
                if (i_in_bus.op == cmcp_pkg::K_LOAD) begin
                    // indexes past the last entry are dropped
                    if (i_in_bus.a_index < NE) begin
                        entry_re[i_in_bus.a_index] = i_in_bus.a_re;
                        entry_im[i_in_bus.a_index] = i_in_bus.a_im;
                    end
                end else begin
                    b_re = '{i_in_bus.b0_re, i_in_bus.b1_re, i_in_bus.b2_re};
                    b_im = '{i_in_bus.b0_im, i_in_bus.b1_im, i_in_bus.b2_im};
                    expected_columns.push_back(column_product(b_re, b_im, i_in_bus.last_in));
                end
            end
            if (i_out_bus.valid && i_out_bus.ready) begin
                seen.parts = {i_out_bus.c2_im, i_out_bus.c2_re, i_out_bus.c1_im,
                              i_out_bus.c1_re, i_out_bus.c0_im, i_out_bus.c0_re};
                seen.last  = i_out_bus.last_out;
                if (expected_columns.size() == 0) begin
                    $display("%0t: result word expected none, got c0_re=%0d last=%0b",
                             $time, $signed(seen.parts[0]), seen.last);
                    o_mismatches++;
                end else begin
                    want = expected_columns.pop_front();
                    for (int i = 0; i < 2*DIM; i++) begin
                        if (seen.parts[i] !== want.parts[i]) begin
                            $display("%0t: %s expected %0d, got %0d", $time, part_names[i],
                                     $signed(want.parts[i]), $signed(seen.parts[i]));
                            o_mismatches++;
                        end
                    end
                    if (seen.last !== want.last) begin
                        $display("%0t: last_out expected %0b, got %0b",
                                 $time, want.last, seen.last);
                        o_mismatches++;
                    end
                end
            end
        end
        o_pending = expected_columns.size();
    end

endmodule

### tb/sv/complex_3x3_matrix_column_product_core_tb.sv
`timescale 1ns / 1ps

module complex_3x3_matrix_column_product_core_tb;

    localparam int SW           = cmcp_pkg::SAMPLE_WIDTH;
    localparam int IW           = cmcp_pkg::IDX_WIDTH;
    localparam int NE           = cmcp_pkg::MAT_ENTRIES;
    localparam int RANDOM_ITEMS = 800;
    localparam int TAIL_ITEMS   = 150;
    localparam int LONG_HOLD    = 80;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 12;
    localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};

    logic clk;
    logic rst_n;
    int   mismatches;
    int   pending;
    int   words_sent;
    int   idle_cycles;
    bit   send_idle_on;
    bit   quiet_tail;
    bit   hold_req;

    cmcp_in_if #(.SAMPLE_WIDTH(SW)) in_bus ();
    cmcp_out_if                     out_bus ();

    complex_3x3_matrix_column_product_core #(.SAMPLE_WIDTH(SW)) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    cmcp_column_checker u_column_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_bus     (in_bus),
        .i_out_bus    (out_bus),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [SW-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return S_MIN;
            1:       return S_MAX;
            2:       return '0;
            default: return SW'($urandom);
        endcase
    endfunction

    // called at a falling edge, returns at a falling edge after the word is taken
    task automatic drive_word(
        input cmcp_pkg::t_kind       kind,
        input logic [IW-1:0]         idx,
        input logic signed [SW-1:0]  are, aim,
        input logic signed [SW-1:0]  b0r, b0i, b1r, b1i, b2r, b2i,
        input logic                  last
    );
        in_bus.valid   <= 1'b1;
        in_bus.op      <= kind;
        in_bus.a_index <= idx;
        in_bus.a_re    <= are;
        in_bus.a_im    <= aim;
        in_bus.b0_re   <= b0r;
        in_bus.b0_im   <= b0i;
        in_bus.b1_re   <= b1r;
        in_bus.b1_im   <= b1i;
        in_bus.b2_re   <= b2r;
        in_bus.b2_im   <= b2i;
        in_bus.last_in <= last;
        @(posedge clk);
        while (!in_bus.ready) @(posedge clk);
        words_sent++;
        @(negedge clk);
        if (send_idle_on && !quiet_tail && $urandom_range(0, 3) == 0) begin
            in_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
    endtask

    // b and last fields of a load are don't-care, so fill them with noise
    task automatic send_load(input logic [IW-1:0] idx, input logic signed [SW-1:0] re, im);
        drive_word(cmcp_pkg::K_LOAD, idx, re, im, rand_sample(), rand_sample(),
                   rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                   1'($urandom_range(0, 1)));
    endtask

    task automatic send_column(input logic signed [SW-1:0] b0r, b0i, b1r, b1i, b2r, b2i,
                               input logic last);
        drive_word(cmcp_pkg::K_COLUMN, IW'($urandom_range(0, 15)), rand_sample(),
                   rand_sample(), b0r, b0i, b1r, b1i, b2r, b2i, last);
    endtask

    task automatic send_random_column(input logic last);
        send_column(rand_sample(), rand_sample(), rand_sample(),
                    rand_sample(), rand_sample(), rand_sample(), last);
    endtask

    task automatic drain();
        in_bus.valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    // result side: random stall bursts, plus one long hold-off on request
    initial begin
        int mode_left;
        bit recv_idle_on;
        out_bus.ready = 1'b0;
        mode_left     = 0;
        recv_idle_on  = 1'b1;
        forever begin
            @(negedge clk);
            if (mode_left == 0) begin
                recv_idle_on = ($urandom_range(0, 2) != 0);
                mode_left    = 40;
            end
            mode_left--;
            if (hold_req) begin
                out_bus.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                hold_req = 1'b0;
            end else if (recv_idle_on && !quiet_tail && $urandom_range(0, 3) == 0) begin
                out_bus.ready <= 1'b0;
                repeat ($urandom_range(0, 13)) @(negedge clk);
            end else begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    initial begin
        idle_cycles = 0;
        wait (rst_n);
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        int kind_pick;
        int n_cols;
        bit held;
        bit drained_mid;
        rst_n          = 1'b0;
        in_bus.valid   = 1'b0;
        in_bus.op      = cmcp_pkg::K_LOAD;
        in_bus.a_index = '0;
        in_bus.a_re    = '0;
        in_bus.a_im    = '0;
        in_bus.b0_re   = '0;
        in_bus.b0_im   = '0;
        in_bus.b1_re   = '0;
        in_bus.b1_im   = '0;
        in_bus.b2_re   = '0;
        in_bus.b2_im   = '0;
        in_bus.last_in = 1'b0;
        send_idle_on   = 1'b1;
        quiet_tail     = 1'b0;
        hold_req       = 1'b0;
        held           = 1'b0;
        drained_mid    = 1'b0;
        words_sent     = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // matrix is all zero straight out of reset
        send_column(S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, 1'b1);
        for (int i = 0; i < NE; i++) send_load(IW'(i), S_MIN, S_MIN);
        send_column(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, 1'b0);
        send_column(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, 1'b1);
        // out-of-range loads leave the matrix alone
        send_load(IW'(9), S_MAX, S_MAX);
        send_load(IW'(15), '0, '0);
        send_column(S_MIN, S_MAX, S_MAX, S_MIN, S_MIN, S_MAX, 1'b0);
        send_load(IW'(0), S_MAX, S_MIN);
        send_load(IW'(4), S_MIN, S_MAX);
        send_load(IW'(8), S_MAX, S_MAX);
        send_column(S_MAX, S_MAX, S_MIN, S_MIN, S_MAX, S_MIN, 1'b1);
        send_column('0, '0, '0, '0, '0, '0, 1'b0);
        send_column(S_MIN, '0, '0, S_MIN, S_MAX, '0, 1'b1);
        drain();

        words_sent = 0;
        while (words_sent < RANDOM_ITEMS) begin
            quiet_tail   = (words_sent >= RANDOM_ITEMS - TAIL_ITEMS);
            send_idle_on = ($urandom_range(0, 2) != 0);
            if (!held && words_sent >= 200) begin
                // back-to-back columns into a stalled output
                held         = 1'b1;
                hold_req     = 1'b1;
                send_idle_on = 1'b0;
                repeat (24) send_random_column(1'($urandom_range(0, 1)));
            end else if (!drained_mid && words_sent >= 450) begin
                drained_mid = 1'b1;
                drain();
            end else begin
                kind_pick = $urandom_range(0, 9);
                if (kind_pick <= 3) begin
                    for (int i = 0; i < NE; i++)
                        send_load(IW'(i), rand_sample(), rand_sample());
                end else if (kind_pick <= 6) begin
                    repeat ($urandom_range(1, 3))
                        send_load(IW'($urandom_range(0, NE - 1)),
                                  rand_sample(), rand_sample());
                end else if (kind_pick == 7) begin
                    send_load(IW'($urandom_range(NE, 15)),
                              rand_sample(), rand_sample());
                end
                if (kind_pick == 9) begin
                    drive_word(cmcp_pkg::t_kind'($urandom_range(0, 1)),
                               IW'($urandom_range(0, 15)),
                               rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                               rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                               1'($urandom_range(0, 1)));
                end else begin
                    n_cols = $urandom_range(1, 8);
                    for (int c = 1; c <= n_cols; c++) send_random_column(c == n_cols);
                end
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### complex_3x3_matrix_column_product_core.f
+incdir+src
src/cmcp_pkg.sv
src/cmcp_if.sv
src/cmcp_front.sv
src/cmcp_back.sv
src/complex_3x3_matrix_column_product_core.sv
tb/sv/cmcp_column_checker.sv
tb/sv/complex_3x3_matrix_column_product_core_tb.sv
